@@ hdl/fire_effect_frame_step_unit_macros.svh @@
// Assertion helpers for the fire step unit. The user supplies clk and rst_n.
`ifndef FIRE_EFFECT_FRAME_STEP_UNIT_MACROS_SVH
`define FIRE_EFFECT_FRAME_STEP_UNIT_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define FE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fire step unit: same-cycle check failed");

// Next-cycle implication, quiet during reset.
`define FE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fire step unit: next-cycle check failed");

`endif

@@ hdl/fe_pkg.sv @@
`default_nettype none

package fe_pkg;

    // Grid geometry
    localparam int COLS       = 32;
    localparam int ROWS       = 128;
    localparam int COL_W      = $clog2(COLS);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int GRID_DEPTH = 1 << ADDR_W;

    // Heat cells and seeding
    localparam int HEAT_W    = 8;
    localparam int SEED_W    = 32;
    localparam int SEED_IDX_W = $clog2(SEED_W);
    localparam int SUM_W     = HEAT_W + 3;
    localparam int SUM_SHIFT = 3;

    typedef logic [HEAT_W-1:0] heat_t;

    localparam heat_t HEAT_MAX    = 8'd255;
    localparam heat_t FIRE_KNEE   = 8'd148;
    localparam heat_t QUIT_KNEE   = 8'd200;
    localparam heat_t DECAY_FLOOR = 8'd4;

    typedef enum logic [1:0] {
        CMD_FIRE = 2'd0,
        CMD_QUIT = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HOT,
        ST_PRIME,
        ST_SWEEP,
        ST_FLUSH,
        ST_RDATA,
        ST_DONE
    } state_t;

    // 3x3 neighbourhood around the current cell; left column already processed
    typedef struct packed {
        heat_t up_l;
        heat_t up_c;
        heat_t up_r;
        heat_t mid_l;
        heat_t mid_c;
        heat_t mid_r;
        heat_t low_l;
        heat_t low_c;
        heat_t low_r;
    } window_t;

endpackage

`default_nettype wire

@@ hdl/fe_if.sv @@
`default_nettype none

// Command channel
interface fe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] seed_bits;
    logic [6:0]  row;
    logic [4:0]  col;

    modport source (output valid, cmd, seed_bits, row, col, input ready);
    modport sink   (input valid, cmd, seed_bits, row, col, output ready);
endinterface

// Result channel
interface fe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       step_done;

    modport source (output valid, pixel, step_done, input ready);
    modport sink   (input valid, pixel, step_done, output ready);
endinterface

`default_nettype wire

@@ hdl/fe_ram.sv @@
`default_nettype none

module fe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/fe_cell_unit.sv @@
`default_nettype none

// Average the eight neighbours into the cell above and decay the centre cell.
module fe_cell_unit (
    input  fe_pkg::window_t win,
    input  logic            quit,
    output fe_pkg::heat_t   new_heat,
    output fe_pkg::heat_t   dec_heat
);
    import fe_pkg::*;

    logic [SUM_W-1:0] sum;

    always_comb
    begin
        sum = SUM_W'(win.up_l) + SUM_W'(win.up_c) + SUM_W'(win.up_r)
            + SUM_W'(win.mid_l) + SUM_W'(win.mid_r)
            + SUM_W'(win.low_l) + SUM_W'(win.low_c) + SUM_W'(win.low_r);
        new_heat = sum[SUM_W-1:SUM_SHIFT];
    end

    always_comb
    begin
        if (quit)
        begin
            priority if (win.mid_c > QUIT_KNEE)
                dec_heat = win.mid_c - 8'd2;
            else if (win.mid_c > DECAY_FLOOR)
                dec_heat = win.mid_c - 8'd1;
            else
                dec_heat = win.mid_c;
        end
        else
        begin
            priority if (win.mid_c > FIRE_KNEE)
                dec_heat = win.mid_c - 8'd1;
            else if (win.mid_c > DECAY_FLOOR)
                dec_heat = win.mid_c - 8'd2;
            else
                dec_heat = win.mid_c;
        end
    end

endmodule

`default_nettype wire

@@ hdl/fire_effect_frame_step_unit.sv @@
// Channel  Role    Payload                        Handshake
// in_ch    sink    cmd, seed_bits, row, col       valid/ready
// out_ch   source  pixel, step_done               valid/ready
//
// Fire or quit step: paced by the grid memory's single write port,
//   one cell written per cycle.
// Read: memory read, capture, then output load.
// Reset: no clearing pass; the grid reads as its reset image until the first step ends.
// Stalls: the next item is accepted while a result waits in the output register;
//   a finished item holds until that register frees.
`default_nettype none

`include "fire_effect_frame_step_unit_macros.svh"

module fire_effect_frame_step_unit (
    input  logic     clk,
    input  logic     rst_n,
    fe_in_if.sink    in_ch,
    fe_out_if.source out_ch
);
    import fe_pkg::*;

    // Seed heat for a column: only the first SEED_W columns have a seed bit
    function automatic heat_t seed_heat(input logic [SEED_W-1:0] seeds, input int col);
        heat_t h;
        h = '0;
        if (col < SEED_W)
        begin
            if (seeds[col[SEED_IDX_W-1:0]])
            begin
                h = HEAT_MAX;
            end
        end
        return h;
    endfunction

    // Control state
    state_t           state_reg, state_next;
    logic             quit_reg, quit_next;
    logic [ROW_W-1:0] y_reg, y_next;
    logic [COL_W-1:0] k_reg, k_next;
    logic             grid_valid_reg, grid_valid_next;
    logic             out_valid_reg, out_valid_next;

    // Payload
    heat_t up_c_reg, up_c_next;
    heat_t line_new_reg [COLS];
    heat_t line_new_next [COLS];
    heat_t line_dec_reg [COLS+1];
    heat_t line_dec_next [COLS+1];
    logic  read_ok_reg, read_ok_next;
    logic  read_hot_reg, read_hot_next;
    heat_t res_pixel_reg, res_pixel_next;
    logic  res_step_reg, res_step_next;
    heat_t out_pixel_reg, out_pixel_next;
    logic  out_step_reg, out_step_next;

    // Combinational
    logic              in_take;
    logic              out_load;
    logic              col_first, col_last, row_last;
    logic [ROW_W-1:0]  y_up, y_up2;
    logic [COL_W:0]    col_ahead, col_wrap;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    heat_t             ram_wdata, ram_rdata, rd_heat;
    window_t           win;
    heat_t             new_heat, dec_heat;

    assign in_take   = in_ch.valid && in_ch.ready;
    assign col_first = (k_reg == '0);
    assign col_last  = (k_reg == COL_W'(COLS - 1));
    assign row_last  = (y_reg == ROW_W'(1));
    assign y_up      = y_reg - ROW_W'(1);
    assign y_up2     = y_reg - ROW_W'(2);
    assign col_ahead = {1'b0, k_reg} + (COL_W+1)'(2);
    assign col_wrap  = col_ahead - (COL_W+1)'(COLS);

    // Before the first step ends, every cell read here reads as cold
    assign rd_heat = grid_valid_reg ? ram_rdata : '0;

    // Grid memory: one row of COLS heat slots per grid row
    fe_ram #(
        .WIDTH (HEAT_W),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Window around cell (y, k). The row above comes from memory one column
    // ahead; the current row and the row below come from the line buffers,
    // whose far taps hold columns k and k+1 and whose tap 0 holds column k-1
    // as just produced. Columns outside the grid read as zero.
    always_comb
    begin
        win.up_l  = col_first ? '0 : line_new_reg[0];
        win.up_c  = up_c_reg;
        win.up_r  = col_last ? '0 : rd_heat;
        win.mid_l = col_first ? '0 : line_dec_reg[0];
        win.mid_c = line_new_reg[COLS-1];
        win.mid_r = col_last ? '0 : line_new_reg[COLS-2];
        win.low_l = col_first ? '0 : line_dec_reg[COLS];
        win.low_c = line_dec_reg[COLS-1];
        win.low_r = col_last ? '0 : line_dec_reg[COLS-2];
    end

    fe_cell_unit u_cell (
        .win      (win),
        .quit     (quit_reg),
        .new_heat (new_heat),
        .dec_heat (dec_heat)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    unique case (in_ch.cmd)
                        CMD_FIRE: state_next = ST_HOT;
                        CMD_QUIT: state_next = ST_PRIME;
                        CMD_READ: state_next = ST_RDATA;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_HOT:
            begin
                if (col_last)
                    state_next = ST_PRIME;
            end
            ST_PRIME:
            begin
                if (!col_first)
                    state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (col_last && row_last)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                if (col_last)
                    state_next = ST_DONE;
            end
            ST_RDATA: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory port and output register control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = {ROW_W'(in_ch.row), COL_W'(in_ch.col)};
            end
            ST_HOT:
            begin
                // re-arm the hot row
                ram_we    = 1'b1;
                ram_waddr = {ROW_W'(ROWS - 1), k_reg};
                ram_wdata = HEAT_MAX;
            end
            ST_PRIME:
            begin
                ram_raddr = {y_up, k_reg};
            end
            ST_SWEEP:
            begin
                // read two columns ahead, running into the next row near the end
                if (col_ahead < (COL_W+1)'(COLS))
                    ram_raddr = {y_up, col_ahead[COL_W-1:0]};
                else
                    ram_raddr = {y_up2, col_wrap[COL_W-1:0]};
                ram_we    = 1'b1;
                ram_waddr = {y_reg, k_reg};
                ram_wdata = dec_heat;
            end
            ST_FLUSH:
            begin
                // top row holds the averaged values and is never decayed
                ram_we    = 1'b1;
                ram_waddr = {ROW_W'(0), k_reg};
                ram_wdata = line_new_reg[COLS-1];
            end
            ST_RDATA:
            begin
                ram_raddr = '0;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || out_ch.ready;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        quit_next       = quit_reg;
        y_next          = y_reg;
        k_next          = k_reg;
        grid_valid_next = grid_valid_reg;
        up_c_next       = up_c_reg;
        line_new_next   = line_new_reg;
        line_dec_next   = line_dec_reg;
        read_ok_next    = read_ok_reg;
        read_hot_next   = read_hot_reg;
        res_pixel_next  = res_pixel_reg;
        res_step_next   = res_step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    k_next         = '0;
                    res_pixel_next = '0;
                    res_step_next  = 1'b0;
                    quit_next      = (in_ch.cmd == CMD_QUIT);
                    read_ok_next   = (32'(in_ch.row) < 32'(ROWS))
                                  && (32'(in_ch.col) < 32'(COLS));
                    read_hot_next  = (32'(in_ch.row) == 32'(ROWS - 1));
                    if (in_ch.cmd == CMD_QUIT)
                        y_next = ROW_W'(ROWS - 1);
                    else
                        y_next = ROW_W'(ROWS - 2);
                    // preload: current row is the seeded row (fire) or the
                    // cleared hot row (quit); row below is hot (fire) or empty
                    for (int j = 0; j < COLS; j++)
                    begin
                        if (in_ch.cmd == CMD_FIRE)
                            line_new_next[j] = seed_heat(in_ch.seed_bits, COLS - 1 - j);
                        else
                            line_new_next[j] = '0;
                    end
                    for (int j = 0; j <= COLS; j++)
                    begin
                        line_dec_next[j] = (in_ch.cmd == CMD_FIRE) ? HEAT_MAX : '0;
                    end
                end
            end
            ST_HOT:
            begin
                k_next = col_last ? '0 : k_reg + COL_W'(1);
            end
            ST_PRIME:
            begin
                if (col_first)
                begin
                    k_next = COL_W'(1);
                end
                else
                begin
                    up_c_next = rd_heat;
                    k_next    = '0;
                end
            end
            ST_SWEEP:
            begin
                // advance both line buffers by one cell
                line_new_next[0] = new_heat;
                line_dec_next[0] = dec_heat;
                for (int j = 1; j < COLS; j++)
                begin
                    line_new_next[j] = line_new_reg[j-1];
                end
                for (int j = 1; j <= COLS; j++)
                begin
                    line_dec_next[j] = line_dec_reg[j-1];
                end
                up_c_next = rd_heat;
                if (col_last)
                begin
                    k_next = '0;
                    if (!row_last)
                        y_next = y_up;
                end
                else
                begin
                    k_next = k_reg + COL_W'(1);
                end
            end
            ST_FLUSH:
            begin
                line_new_next[0] = '0;
                for (int j = 1; j < COLS; j++)
                begin
                    line_new_next[j] = line_new_reg[j-1];
                end
                if (col_last)
                begin
                    k_next          = '0;
                    grid_valid_next = 1'b1;
                    res_pixel_next  = '0;
                    res_step_next   = 1'b1;
                end
                else
                begin
                    k_next = k_reg + COL_W'(1);
                end
            end
            ST_RDATA:
            begin
                res_step_next = 1'b0;
                if (!read_ok_reg)
                    res_pixel_next = '0;
                else if (grid_valid_reg)
                    res_pixel_next = ram_rdata;
                else
                    res_pixel_next = read_hot_reg ? HEAT_MAX : '0;
            end
            ST_DONE:
            begin
                res_step_next = res_step_reg;
            end
            default:
            begin
                k_next = '0;
            end
        endcase
    end

    // Output register: hold until taken, reload as soon as it frees
    always_comb
    begin
        out_valid_next = out_load || (out_valid_reg && !out_ch.ready);
        out_pixel_next = out_load ? res_pixel_reg : out_pixel_reg;
        out_step_next  = out_load ? res_step_reg : out_step_reg;
    end

    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.pixel     = out_pixel_reg;
    assign out_ch.step_done = out_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            quit_reg       <= 1'b0;
            y_reg          <= '0;
            k_reg          <= '0;
            grid_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            quit_reg       <= quit_next;
            y_reg          <= y_next;
            k_reg          <= k_next;
            grid_valid_reg <= grid_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        up_c_reg      <= up_c_next;
        line_new_reg  <= line_new_next;
        line_dec_reg  <= line_dec_next;
        read_ok_reg   <= read_ok_next;
        read_hot_reg  <= read_hot_next;
        res_pixel_reg <= res_pixel_next;
        res_step_reg  <= res_step_next;
        out_pixel_reg <= out_pixel_next;
        out_step_reg  <= out_step_next;
    end

    // Column counter stays on the grid while sweeping
    `FE_ASSERT_IMP(a_sweep_col_range, state_reg == ST_SWEEP, 32'(k_reg) < 32'(COLS))
    // Sweep never reaches the top row as the current row
    `FE_ASSERT_IMP(a_sweep_row_range, state_reg == ST_SWEEP, y_reg != '0)
    // Decayed write-back never lands on the cell being fetched
    `FE_ASSERT_IMP(a_sweep_no_overlap, state_reg == ST_SWEEP, ram_waddr != ram_raddr)
    // Finishing the top row marks the whole grid written
    `FE_ASSERT_NEXT(a_flush_sets_valid, state_reg == ST_FLUSH && col_last, grid_valid_reg && state_reg == ST_DONE)
    // A frame step result carries no pixel
    `FE_ASSERT_IMP(a_step_result_clean, out_load && res_step_reg, res_pixel_reg == '0)

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fe_pkg::*;

    // Command code with no meaning to the block: it must change nothing
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Longest run of cycles without any item moving before the run is abandoned.
    // Allow for a full frame step plus stalls several times over.
    localparam int STALL_LIMIT = 25000;
    localparam int TAIL_CYCLES = 16;

    typedef struct {
        heat_t pixel;
        logic  step_done;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fe_in_if  in_ch();
    fe_out_if out_ch();

    fire_effect_frame_step_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #1 clk = ~clk;

    // Local copy of the heat grid, advanced once per accepted item
    heat_t fire_grid [ROWS][COLS];

    // Results owed by the block, oldest first
    frame_result_t awaited_results [$];

    int sender_idle_pct   = 0;
    int receiver_stall_pct = 0;
    int error_count       = 0;
    int results_checked   = 0;
    int fire_steps        = 0;
    int quit_steps        = 0;
    int cell_reads        = 0;
    int unused_cmds       = 0;
    int quiet_cycles      = 0;

    // ---------------------------------------------------------------
    // Grid model
    // ---------------------------------------------------------------

    // Load the reset image: hot bottom row, everything else cold
    task automatic reset_fire_model();
        for (int y = 0; y < ROWS; y++)
            for (int x = 0; x < COLS; x++)
                fire_grid[y][x] = (y == ROWS - 1) ? HEAT_MAX : '0;
    endtask

    // Cells outside the grid read as cold
    function automatic int unsigned cell_heat(input int y, input int x);
        if (y < 0 || y >= ROWS || x < 0 || x >= COLS)
            return 0;
        return fire_grid[y][x];
    endfunction

    // In-place sweep, bottom row first, left to right within a row.
    // Each cell rewrites the one above it from the eight neighbours, then decays.
    function automatic void sweep_heat(input int top_y, input bit fading);
        int unsigned sum;
        heat_t       v;
        for (int y = top_y; y > 0; y--) begin
            for (int x = 0; x < COLS; x++) begin
                sum = cell_heat(y, x - 1) + cell_heat(y, x + 1)
                    + cell_heat(y + 1, x) + cell_heat(y - 1, x)
                    + cell_heat(y - 1, x - 1) + cell_heat(y - 1, x + 1)
                    + cell_heat(y + 1, x - 1) + cell_heat(y + 1, x + 1);
                fire_grid[y-1][x] = heat_t'(sum >> SUM_SHIFT);
                v = fire_grid[y][x];
                if (fading) begin
                    if (v > QUIT_KNEE)
                        v = v - 8'd2;
                    else if (v > DECAY_FLOOR)
                        v = v - 8'd1;
                end
                else begin
                    if (v > FIRE_KNEE)
                        v = v - 8'd1;
                    else if (v > DECAY_FLOOR)
                        v = v - 8'd2;
                end
                fire_grid[y][x] = v;
            end
        end
    endfunction

    // Advance the grid for one item and work out the result it owes
    function automatic frame_result_t advance_fire_model(input logic [1:0] cmd,
                                                         input logic [31:0] seeds,
                                                         input logic [6:0] row,
                                                         input logic [4:0] col);
        frame_result_t res;
        res.pixel     = '0;
        res.step_done = 1'b0;
        case (cmd)
            CMD_FIRE: begin
                // Re-arm the hot row, seed the row above it, columns past
                // the seed word stay cold
                for (int x = 0; x < COLS; x++) begin
                    fire_grid[ROWS-1][x] = HEAT_MAX;
                    fire_grid[ROWS-2][x] = (x < SEED_W && seeds[x]) ? HEAT_MAX : '0;
                end
                sweep_heat(ROWS - 2, 1'b0);
                res.step_done = 1'b1;
            end
            CMD_QUIT: begin
                for (int x = 0; x < COLS; x++)
                    fire_grid[ROWS-1][x] = '0;
                sweep_heat(ROWS - 1, 1'b1);
                res.step_done = 1'b1;
            end
            CMD_READ: begin
                // Reads outside the grid give a cold pixel
                if (int'(row) < ROWS && int'(col) < COLS)
                    res.pixel = fire_grid[row][col];
            end
            default: ;
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Command side
    // ---------------------------------------------------------------

    // Offer one item, idling beforehand at the current rate; the expectation
    // is recorded at the edge where the block takes it
    task automatic send_item(input logic [1:0] cmd, input logic [31:0] seeds,
                             input logic [6:0] row, input logic [4:0] col);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.seed_bits <= seeds;
        in_ch.row       <= row;
        in_ch.col       <= col;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
        awaited_results.push_back(advance_fire_model(cmd, seeds, row, col));
        case (cmd)
            CMD_FIRE: fire_steps++;
            CMD_QUIT: quit_steps++;
            CMD_READ: cell_reads++;
            default:  unused_cmds++;
        endcase
    endtask

    task automatic read_cell(input int y, input int x);
        send_item(CMD_READ, $urandom, 7'(y), 5'(x));
    endtask

    task automatic fire_step(input logic [31:0] seeds);
        send_item(CMD_FIRE, seeds, 7'($urandom), 5'($urandom));
    endtask

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------

    // Hold off results at the current stall rate
    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) < receiver_stall_pct) ? 1'b0 : 1'b1;

    // Compare every taken result with the oldest one owed
    always @(posedge clk) begin
        frame_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (awaited_results.size() == 0) begin
                $error("result with nothing owed: pixel %0d step_done %0b",
                       out_ch.pixel, out_ch.step_done);
                error_count++;
            end
            else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (out_ch.pixel !== want.pixel) begin
                    $error("pixel: expected %0d, got %0d", want.pixel, out_ch.pixel);
                    error_count++;
                end
                if (out_ch.step_done !== want.step_done) begin
                    $error("step_done: expected %0b, got %0b",
                           want.step_done, out_ch.step_done);
                    error_count++;
                end
            end
        end
    end

    // Abandon the run if nothing moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // The grid must read as its reset image before any step
    task automatic test_reset_image();
        read_cell(ROWS - 1, 0);
        read_cell(ROWS - 1, COLS - 1);
        read_cell(0, 0);
        read_cell(ROWS - 2, 15);
    endtask

    // Seed extremes: fully lit, fully dark and alternating columns
    task automatic test_fire_seeds();
        fire_step(32'hFFFF_FFFF);
        read_cell(ROWS - 2, 0);
        read_cell(ROWS - 3, COLS - 1);
        read_cell(0, COLS - 1);
        fire_step(32'h0000_0000);
        read_cell(ROWS - 2, 7);
        read_cell(ROWS - 1, 31);
        fire_step(32'hAAAA_AAAA);
        read_cell(ROWS - 2, 1);
        fire_step(32'h5555_5555);
        read_cell(ROWS - 3, 0);
        read_cell(ROWS - 4, 16);
    endtask

    // Fade steps: hot row cleared, sweep starts on the bottom row itself
    task automatic test_quit_fade();
        send_item(CMD_QUIT, 32'hFFFF_FFFF, 7'h7F, 5'h1F);
        read_cell(ROWS - 1, 3);
        send_item(CMD_QUIT, 32'h0, 7'h0, 5'h0);
        read_cell(ROWS - 2, 30);
        read_cell(ROWS - 5, 12);
    endtask

    // Unused command: cold result, grid untouched
    task automatic test_unused_command();
        send_item(CMD_UNUSED, 32'hFFFF_FFFF, 7'h7F, 5'h1F);
        send_item(CMD_UNUSED, 32'h0, 7'h0, 5'h0);
        read_cell(ROWS - 2, 5);
    endtask

    // Fire steps and reads, the reads favouring the hot bottom rows;
    // occasional fades and unused commands
    task automatic test_random_traffic(input int items, input int idle_pct,
                                       input int stall_pct);
        int pick;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(99);
            if (pick < 40)
                fire_step($urandom);
            else if (pick < 48)
                send_item(CMD_QUIT, $urandom, 7'($urandom), 5'($urandom));
            else if (pick < 95) begin
                if ($urandom_range(1))
                    read_cell($urandom_range(ROWS - 1, ROWS - 8), $urandom_range(COLS - 1));
                else
                    read_cell($urandom_range(ROWS - 1), $urandom_range(COLS - 1));
            end
            else
                send_item(CMD_UNUSED, $urandom, 7'($urandom), 5'($urandom));
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.cmd       = CMD_READ;
        in_ch.seed_bits = '0;
        in_ch.row       = '0;
        in_ch.col       = '0;
        out_ch.ready    = 1'b0;
        reset_fire_model();

        // Single reset pulse at the start of the run
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_image();
        test_fire_seeds();
        test_quit_fade();
        test_unused_command();

        test_random_traffic(30, 0, 0);
        test_random_traffic(30, 57, 0);
        test_random_traffic(30, 0, 57);
        test_random_traffic(30, 20, 20);

        // Drop valid, drain what is owed, then give stray results time to show
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d fire steps, %0d fade steps, %0d cell reads, %0d unused commands",
                 fire_steps, quit_steps, cell_reads, unused_cmds);
        $display("%0d results checked under four idle and stall mixes, %0d mismatches",
                 results_checked, error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
